/* rtl/hhd_pkg.sv */
// Package with shared types, constants and the canonical Huffman decode tables.
`timescale 1ns / 1ps
`default_nettype none
package hhd_pkg;
	localparam int unsigned NumSym = 257;
	localparam int unsigned MaxLen = 30;
	localparam logic [8:0] EosSym = 9'd256;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  symbol;
		logic        symbol_valid;
		logic        error_code;
		logic        end_of_string;
		logic [15:0] symbol_total;
		logic [4:0]  leftover_bits;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} be_state_t;

	// Number of codes of each length, lengths 5 to 30.
	function automatic logic [7:0] len_count(input logic [4:0] len);
		logic [7:0] n;
		case (len)
			5'd5:  n = 8'd10;
			5'd6:  n = 8'd26;
			5'd7:  n = 8'd32;
			5'd8:  n = 8'd6;
			5'd10: n = 8'd5;
			5'd11: n = 8'd3;
			5'd12: n = 8'd2;
			5'd13: n = 8'd6;
			5'd14: n = 8'd2;
			5'd15: n = 8'd3;
			5'd19: n = 8'd3;
			5'd20: n = 8'd8;
			5'd21: n = 8'd13;
			5'd22: n = 8'd26;
			5'd23: n = 8'd29;
			5'd24: n = 8'd12;
			5'd25: n = 8'd4;
			5'd26: n = 8'd15;
			5'd27: n = 8'd19;
			5'd28: n = 8'd29;
			5'd30: n = 8'd4;
			default: n = 8'd0;
		endcase
		return n;
	endfunction

	// First canonical code value of each length (30-bit, right aligned).
	function automatic logic [29:0] first_code(input logic [4:0] len);
		logic [29:0] c;
		c = '0;
		for (int l = 1; l <= 30; l++) begin
			if (l[4:0] == len) begin
				return c;
			end
			c = (c + 30'(len_count(l[4:0]))) << 1;
		end
		return c;
	endfunction

	// Index of the first symbol of each length in the length-sorted list.
	function automatic logic [8:0] first_rank(input logic [4:0] len);
		logic [8:0] r;
		r = '0;
		for (int l = 1; l <= 30; l++) begin
			if (l[4:0] == len) begin
				return r;
			end
			r = r + 9'(len_count(l[4:0]));
		end
		return r;
	endfunction

	// Symbols sorted by code length, then by value.
	function automatic logic [8:0] rank_sym(input logic [8:0] rank);
		logic [8:0] s;
		case (rank)
			9'd0: s = 9'd48;  9'd1: s = 9'd49;  9'd2: s = 9'd50;  9'd3: s = 9'd97;
			9'd4: s = 9'd99;  9'd5: s = 9'd101; 9'd6: s = 9'd105; 9'd7: s = 9'd111;
			9'd8: s = 9'd115; 9'd9: s = 9'd116;
			9'd10: s = 9'd32; 9'd11: s = 9'd37; 9'd12: s = 9'd45; 9'd13: s = 9'd46;
			9'd14: s = 9'd47; 9'd15: s = 9'd51; 9'd16: s = 9'd52; 9'd17: s = 9'd53;
			9'd18: s = 9'd54; 9'd19: s = 9'd55; 9'd20: s = 9'd56; 9'd21: s = 9'd57;
			9'd22: s = 9'd61; 9'd23: s = 9'd65; 9'd24: s = 9'd95; 9'd25: s = 9'd98;
			9'd26: s = 9'd100; 9'd27: s = 9'd102; 9'd28: s = 9'd103; 9'd29: s = 9'd104;
			9'd30: s = 9'd108; 9'd31: s = 9'd109; 9'd32: s = 9'd110; 9'd33: s = 9'd112;
			9'd34: s = 9'd114; 9'd35: s = 9'd117;
			9'd36: s = 9'd58; 9'd37: s = 9'd66; 9'd38: s = 9'd67; 9'd39: s = 9'd68;
			9'd40: s = 9'd69; 9'd41: s = 9'd70; 9'd42: s = 9'd71; 9'd43: s = 9'd72;
			9'd44: s = 9'd73; 9'd45: s = 9'd74; 9'd46: s = 9'd75; 9'd47: s = 9'd76;
			9'd48: s = 9'd77; 9'd49: s = 9'd78; 9'd50: s = 9'd79; 9'd51: s = 9'd80;
			9'd52: s = 9'd81; 9'd53: s = 9'd82; 9'd54: s = 9'd83; 9'd55: s = 9'd84;
			9'd56: s = 9'd85; 9'd57: s = 9'd86; 9'd58: s = 9'd87; 9'd59: s = 9'd89;
			9'd60: s = 9'd106; 9'd61: s = 9'd107; 9'd62: s = 9'd113; 9'd63: s = 9'd118;
			9'd64: s = 9'd119; 9'd65: s = 9'd120; 9'd66: s = 9'd121; 9'd67: s = 9'd122;
			9'd68: s = 9'd38; 9'd69: s = 9'd42; 9'd70: s = 9'd44; 9'd71: s = 9'd59;
			9'd72: s = 9'd88; 9'd73: s = 9'd90;
			9'd74: s = 9'd33; 9'd75: s = 9'd34; 9'd76: s = 9'd40; 9'd77: s = 9'd41;
			9'd78: s = 9'd63;
			9'd79: s = 9'd39; 9'd80: s = 9'd43; 9'd81: s = 9'd124;
			9'd82: s = 9'd35; 9'd83: s = 9'd62;
			9'd84: s = 9'd0; 9'd85: s = 9'd36; 9'd86: s = 9'd64; 9'd87: s = 9'd91;
			9'd88: s = 9'd93; 9'd89: s = 9'd126;
			9'd90: s = 9'd94; 9'd91: s = 9'd125;
			9'd92: s = 9'd60; 9'd93: s = 9'd96; 9'd94: s = 9'd123;
			9'd95: s = 9'd92; 9'd96: s = 9'd195; 9'd97: s = 9'd208;
			9'd98: s = 9'd128; 9'd99: s = 9'd130; 9'd100: s = 9'd131; 9'd101: s = 9'd162;
			9'd102: s = 9'd184; 9'd103: s = 9'd194; 9'd104: s = 9'd224; 9'd105: s = 9'd226;
			9'd106: s = 9'd153; 9'd107: s = 9'd161; 9'd108: s = 9'd167; 9'd109: s = 9'd172;
			9'd110: s = 9'd176; 9'd111: s = 9'd177; 9'd112: s = 9'd179; 9'd113: s = 9'd209;
			9'd114: s = 9'd216; 9'd115: s = 9'd217; 9'd116: s = 9'd227; 9'd117: s = 9'd229;
			9'd118: s = 9'd230;
			9'd119: s = 9'd129; 9'd120: s = 9'd132; 9'd121: s = 9'd133; 9'd122: s = 9'd134;
			9'd123: s = 9'd136; 9'd124: s = 9'd146; 9'd125: s = 9'd154; 9'd126: s = 9'd156;
			9'd127: s = 9'd160; 9'd128: s = 9'd163; 9'd129: s = 9'd164; 9'd130: s = 9'd169;
			9'd131: s = 9'd170; 9'd132: s = 9'd173; 9'd133: s = 9'd178; 9'd134: s = 9'd181;
			9'd135: s = 9'd185; 9'd136: s = 9'd186; 9'd137: s = 9'd187; 9'd138: s = 9'd189;
			9'd139: s = 9'd190; 9'd140: s = 9'd196; 9'd141: s = 9'd198; 9'd142: s = 9'd228;
			9'd143: s = 9'd232; 9'd144: s = 9'd233;
			9'd145: s = 9'd1; 9'd146: s = 9'd135; 9'd147: s = 9'd137; 9'd148: s = 9'd138;
			9'd149: s = 9'd139; 9'd150: s = 9'd140; 9'd151: s = 9'd141; 9'd152: s = 9'd143;
			9'd153: s = 9'd147; 9'd154: s = 9'd149; 9'd155: s = 9'd150; 9'd156: s = 9'd151;
			9'd157: s = 9'd152; 9'd158: s = 9'd155; 9'd159: s = 9'd157; 9'd160: s = 9'd158;
			9'd161: s = 9'd165; 9'd162: s = 9'd166; 9'd163: s = 9'd168; 9'd164: s = 9'd174;
			9'd165: s = 9'd175; 9'd166: s = 9'd180; 9'd167: s = 9'd182; 9'd168: s = 9'd183;
			9'd169: s = 9'd188; 9'd170: s = 9'd191; 9'd171: s = 9'd197; 9'd172: s = 9'd231;
			9'd173: s = 9'd239;
			9'd174: s = 9'd9; 9'd175: s = 9'd142; 9'd176: s = 9'd144; 9'd177: s = 9'd145;
			9'd178: s = 9'd148; 9'd179: s = 9'd159; 9'd180: s = 9'd171; 9'd181: s = 9'd206;
			9'd182: s = 9'd215; 9'd183: s = 9'd225; 9'd184: s = 9'd236; 9'd185: s = 9'd237;
			9'd186: s = 9'd199; 9'd187: s = 9'd207; 9'd188: s = 9'd234; 9'd189: s = 9'd235;
			9'd190: s = 9'd192; 9'd191: s = 9'd193; 9'd192: s = 9'd200; 9'd193: s = 9'd201;
			9'd194: s = 9'd202; 9'd195: s = 9'd205; 9'd196: s = 9'd210; 9'd197: s = 9'd213;
			9'd198: s = 9'd218; 9'd199: s = 9'd219; 9'd200: s = 9'd238; 9'd201: s = 9'd240;
			9'd202: s = 9'd242; 9'd203: s = 9'd243; 9'd204: s = 9'd255;
			9'd205: s = 9'd203; 9'd206: s = 9'd204; 9'd207: s = 9'd211; 9'd208: s = 9'd212;
			9'd209: s = 9'd214; 9'd210: s = 9'd221; 9'd211: s = 9'd222; 9'd212: s = 9'd223;
			9'd213: s = 9'd241; 9'd214: s = 9'd244; 9'd215: s = 9'd245; 9'd216: s = 9'd246;
			9'd217: s = 9'd247; 9'd218: s = 9'd248; 9'd219: s = 9'd250; 9'd220: s = 9'd251;
			9'd221: s = 9'd252; 9'd222: s = 9'd253; 9'd223: s = 9'd254;
			9'd224: s = 9'd2; 9'd225: s = 9'd3; 9'd226: s = 9'd4; 9'd227: s = 9'd5;
			9'd228: s = 9'd6; 9'd229: s = 9'd7; 9'd230: s = 9'd8; 9'd231: s = 9'd11;
			9'd232: s = 9'd12; 9'd233: s = 9'd14; 9'd234: s = 9'd15; 9'd235: s = 9'd16;
			9'd236: s = 9'd17; 9'd237: s = 9'd18; 9'd238: s = 9'd19; 9'd239: s = 9'd20;
			9'd240: s = 9'd21; 9'd241: s = 9'd23; 9'd242: s = 9'd24; 9'd243: s = 9'd25;
			9'd244: s = 9'd26; 9'd245: s = 9'd27; 9'd246: s = 9'd28; 9'd247: s = 9'd29;
			9'd248: s = 9'd30; 9'd249: s = 9'd31; 9'd250: s = 9'd127; 9'd251: s = 9'd220;
			9'd252: s = 9'd249;
			9'd253: s = 9'd10; 9'd254: s = 9'd13; 9'd255: s = 9'd22; 9'd256: s = 9'd256;
			default: s = 9'd0;
		endcase
		return s;
	endfunction
endpackage
`default_nettype wire

/* rtl/hhd_if.sv */
// Valid/ready channel interface carrying one payload type.
`timescale 1ns / 1ps
`default_nettype none
interface hhd_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/hhd_front.sv */
// Input stage: takes bytes and places them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module hhd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hhd_pkg::in_item_t in_item,
	output logic                  q_valid,
	input  wire logic             q_pop,
	output hhd_pkg::in_item_t     q_item
);
	import hhd_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

/* rtl/hhd_back.sv */
// Decode stage: shifts four bits a cycle through a canonical-code matcher while in its decode state.
`timescale 1ns / 1ps
`default_nettype none
module hhd_back #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	output logic                   q_pop,
	input  wire hhd_pkg::in_item_t q_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hhd_pkg::out_item_t     out_item
);
	import hhd_pkg::*;

	localparam logic [COUNT_BITS-1:0] CountMax = '1;

	be_state_t       state_q, state_d;
	logic [29:0]     acc_q;
	logic [4:0]      nbits_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]      byte_q;
	logic            fin_q;
	logic            half_q;
	logic [1:0]      nres_q;
	out_item_t       res_q [2];
	logic [1:0]      emit_q;
	out_item_t       ob_q;
	logic            ob_valid_q;

	// Combinational walk over four bits of the current half byte.
	logic [29:0]     acc_w [5];
	logic [4:0]      nb_w [5];
	logic [COUNT_BITS-1:0] cnt_w [5];
	logic [1:0]      nr_w [5];
	out_item_t       rs_w [5][2];
	logic [8:0]      sym;
	logic [29:0]     off;
	logic            hit;
	logic [3:0]      nib;
	logic            ob_load;
	out_item_t       res_mod [2];
	logic [1:0]      last_idx;

	assign nib = half_q ? byte_q[3:0] : byte_q[7:4];

	always_comb begin
		acc_w[0] = acc_q;
		nb_w[0]  = nbits_q;
		cnt_w[0] = count_q;
		nr_w[0]  = nres_q;
		rs_w[0][0] = res_q[0];
		rs_w[0][1] = res_q[1];
		sym = '0;
		off = '0;
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			acc_w[i+1] = {acc_w[i][28:0], nib[3-i]};
			nb_w[i+1]  = nb_w[i] + 5'd1;
			cnt_w[i+1] = cnt_w[i];
			nr_w[i+1]  = nr_w[i];
			rs_w[i+1][0] = rs_w[i][0];
			rs_w[i+1][1] = rs_w[i][1];
			off = acc_w[i+1] - first_code(nb_w[i+1]);
			hit = (acc_w[i+1] >= first_code(nb_w[i+1]))
				&& (off < 30'(len_count(nb_w[i+1])));
			sym = rank_sym(first_rank(nb_w[i+1]) + off[8:0]);
			if (hit) begin
				if (nr_w[i] != 2'd2) begin
					rs_w[i+1][nr_w[i][0]] = '0;
					if (sym == EosSym) begin
						rs_w[i+1][nr_w[i][0]].error_code = 1'b1;
					end else begin
						rs_w[i+1][nr_w[i][0]].symbol       = sym[7:0];
						rs_w[i+1][nr_w[i][0]].symbol_valid = 1'b1;
					end
					nr_w[i+1] = nr_w[i] + 2'd1;
				end
				if (sym != EosSym && cnt_w[i] != CountMax) begin
					cnt_w[i+1] = cnt_w[i] + 1'b1;
				end
				acc_w[i+1] = '0;
				nb_w[i+1]  = '0;
			end else if (nb_w[i+1] >= 5'(MaxLen)) begin
				acc_w[i+1] = '0;
				nb_w[i+1]  = '0;
			end
		end
	end

	// Attach the end-of-string marks to the last result of a final byte.
	always_comb begin
		res_mod[0] = res_q[0];
		res_mod[1] = res_q[1];
		last_idx   = nres_q;
		if (fin_q) begin
			if (nres_q == 2'd0) begin
				res_mod[0] = '0;
				last_idx   = 2'd1;
			end
			res_mod[last_idx[1]].end_of_string = 1'b1;
			res_mod[last_idx[1]].symbol_total  =
				16'(count_q[((COUNT_BITS > 16) ? 16 : COUNT_BITS)-1:0]);
			res_mod[last_idx[1]].leftover_bits = nbits_q;
		end
	end

	assign out_valid = ob_valid_q;
	assign out_item  = ob_q;
	assign ob_load   = (state_q == ST_EMIT) && (emit_q != 2'd0)
		&& (!ob_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (half_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_q == 2'd0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q <= q_item.data_byte;
			fin_q  <= q_item.final_byte;
		end
		if (state_q == ST_DECODE) begin
			res_q[0] <= rs_w[4][0];
			res_q[1] <= rs_w[4][1];
		end
		if (ob_load) begin
			ob_q <= (emit_q == 2'd2 || last_idx == 2'd1) ? res_mod[0] : res_mod[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_q      <= '0;
			nbits_q    <= '0;
			count_q    <= '0;
			half_q     <= 1'b0;
			nres_q     <= '0;
			emit_q     <= '0;
			ob_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ob_load) begin
				ob_valid_q <= 1'b1;
			end else if (out_ready) begin
				ob_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					half_q <= 1'b0;
					nres_q <= '0;
				end
				ST_DECODE: begin
					acc_q   <= acc_w[4];
					nbits_q <= nb_w[4];
					count_q <= cnt_w[4];
					nres_q  <= nr_w[4];
					half_q  <= ~half_q;
					if (half_q) begin
						emit_q <= (fin_q && nr_w[4] == 2'd0) ? 2'd1 : nr_w[4];
					end
				end
				ST_EMIT: begin
					if (ob_load) begin
						emit_q <= emit_q - 2'd1;
						if (emit_q == 2'd1 && fin_q) begin
							acc_q   <= '0;
							nbits_q <= '0;
							count_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/hpack_huffman_decoder.sv */
// Top level of the HPACK Huffman string decoder.
`timescale 1ns / 1ps
`default_nettype none
// Decodes an HPACK Huffman-coded string one byte per request, most significant
// bit first, and returns one result per decoded symbol (at most two per byte),
// one error result per EOS code found, and marks the last result of the final
// byte with the saturating symbol count and the number of padding bits left.
// A byte is loaded from the queue in the idle state, then passes through the
// canonical-code matcher one half byte at a time in the decode state. Its
// results then move one at a time into the output register in the emit
// state, after which the stage returns to idle. A result that waits for the
// output register to drain holds the stage in the emit state. A two-entry
// input queue decouples intake from decoding, and the output register lets a
// new byte enter while the previous result still waits.
module hpack_huffman_decoder #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hhd_if.sink       in_ch,
	hhd_if.source     out_ch
);
	import hhd_pkg::*;

	logic      q_valid;
	logic      q_pop;
	in_item_t  q_item;

	hhd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_item  (in_ch.payload),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	hhd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.payload)
	);

	// A result never carries both a symbol and an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.payload.symbol_valid && out_ch.payload.error_code))
		else $error("symbol and error set together");

	// Padding count stays below the longest code length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload.end_of_string)
			|-> (out_ch.payload.leftover_bits < 5'd30))
		else $error("leftover bits out of range");

	// The queue is only read when it holds a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue read while empty");
endmodule
`default_nettype wire

/* sim/tb_hpack_huffman_decoder.sv */
// Self-checking testbench for the HPACK Huffman string decoder.
`timescale 1ns / 1ps
module tb_hpack_huffman_decoder;
	import hhd_pkg::*;

	localparam int IdleLimit = 3000;
	localparam logic [8:0] EosCode = 9'd256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hhd_if #(.T(in_item_t))  in_ch ();
	hhd_if #(.T(out_item_t)) out_ch ();

	hpack_huffman_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #1 clk = ~clk;

	// Code lengths of the fixed table, symbols 0 to 255 and then EOS.
	int code_len [257] = '{
		13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
		28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
		6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
		5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
		13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
		7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
		15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
		6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
		20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
		24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
		22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
		21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
		26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
		19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
		20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
		26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
		30
	};
	logic [29:0] code_word [257];
	int          code_sym [bit [34:0]];
	int          short_syms [$];

	in_item_t  pending_bytes [$];
	out_item_t expected_results [$];

	logic [29:0] dec_accum;
	int          dec_bits;
	logic [15:0] dec_count;

	int errors = 0;
	int idle_cycles = 0;
	int in_wait = 0;
	int out_wait = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;
	int n_bytes = 0;
	int n_results = 0;
	int n_strings = 0;
	int n_eos = 0;

	function automatic void build_code_table();
		logic [29:0] c;
		c = '0;
		for (int len = 1; len <= 30; len++) begin
			for (int s = 0; s < 257; s++) begin
				if (code_len[s] == len) begin
					code_word[s] = c;
					code_sym[{5'(len), c}] = s;
					c++;
				end
			end
			c = c << 1;
		end
		for (int s = 0; s < 256; s++)
			if (code_len[s] <= 8) short_syms.push_back(s);
	endfunction

	// Decodes one byte against the running string state and queues its results.
	function automatic void decode_byte(in_item_t it);
		out_item_t r [$];
		out_item_t o;
		int s;
		for (int i = 7; i >= 0; i--) begin
			dec_accum = {dec_accum[28:0], it.data_byte[i]};
			dec_bits++;
			if (code_sym.exists({5'(dec_bits), dec_accum})) begin
				s = code_sym[{5'(dec_bits), dec_accum}];
				if (r.size() < 2) begin
					o = '0;
					if (s == EosCode) begin
						o.error_code = 1'b1;
					end else begin
						o.symbol = 8'(s);
						o.symbol_valid = 1'b1;
					end
					r.push_back(o);
				end
				if (s != EosCode && dec_count != 16'hFFFF) dec_count++;
				dec_accum = '0;
				dec_bits = 0;
			end else if (dec_bits >= 30) begin
				dec_accum = '0;
				dec_bits = 0;
			end
		end
		if (it.final_byte) begin
			if (r.size() == 0) r.push_back('0);
			r[r.size()-1].end_of_string = 1'b1;
			r[r.size()-1].symbol_total = dec_count;
			r[r.size()-1].leftover_bits = 5'(dec_bits);
			dec_accum = '0;
			dec_bits = 0;
			dec_count = '0;
		end
		foreach (r[k]) expected_results.push_back(r[k]);
	endfunction

	// Encodes a symbol list into bytes; pad_mode 0 pads with ones, 1 with random
	// bits, 2 adds an extra byte of ones after the normal padding.
	task automatic queue_string(int syms [$], int pad_mode);
		bit bits [$];
		in_item_t it;
		foreach (syms[k]) begin
			for (int b = code_len[syms[k]] - 1; b >= 0; b--)
				bits.push_back(code_word[syms[k]][b]);
			if (syms[k] == EosCode) n_eos++;
		end
		while (bits.size() % 8 != 0 || bits.size() == 0)
			bits.push_back(pad_mode == 1 ? 1'($urandom_range(0, 1)) : 1'b1);
		if (pad_mode == 2)
			repeat (8) bits.push_back(1'b1);
		for (int k = 0; k < bits.size(); k += 8) begin
			for (int b = 0; b < 8; b++) it.data_byte[7-b] = bits[k+b];
			it.final_byte = (k + 8 == bits.size());
			pending_bytes.push_back(it);
		end
		n_strings++;
	endtask

	task automatic queue_noise(int nbytes, bit terminate);
		in_item_t it;
		for (int k = 0; k < nbytes; k++) begin
			it.data_byte = 8'($urandom);
			it.final_byte = terminate && (k == nbytes - 1);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic report_mismatch(string field, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				decode_byte(in_ch.payload);
				n_bytes++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_wait > 0) begin
					in_wait--;
					in_ch.valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.payload <= pending_bytes.pop_front();
					if ($urandom_range(0, 39) == 0) in_quiet = ~in_quiet;
					in_wait = in_quiet ? 0 : $urandom_range(0, 19);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result count", n_results, n_results - 1);
				end else begin
					out_item_t e;
					out_item_t g;
					e = expected_results.pop_front();
					g = out_ch.payload;
					if (g.symbol !== e.symbol) report_mismatch("symbol", g.symbol, e.symbol);
					if (g.symbol_valid !== e.symbol_valid)
						report_mismatch("symbol_valid", g.symbol_valid, e.symbol_valid);
					if (g.error_code !== e.error_code)
						report_mismatch("error_code", g.error_code, e.error_code);
					if (g.end_of_string !== e.end_of_string)
						report_mismatch("end_of_string", g.end_of_string, e.end_of_string);
					if (g.symbol_total !== e.symbol_total)
						report_mismatch("symbol_total", g.symbol_total, e.symbol_total);
					if (g.leftover_bits !== e.leftover_bits)
						report_mismatch("leftover_bits", g.leftover_bits, e.leftover_bits);
				end
				if ($urandom_range(0, 39) == 0) out_quiet = ~out_quiet;
				out_wait = out_quiet ? 0 : $urandom_range(0, 19);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Timeout: no progress for %0d cycles", IdleLimit);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int syms [$];
		int r;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		dec_accum = '0;
		dec_bits = 0;
		dec_count = '0;
		build_code_table();

		// Directed strings: short and longest codes, both ends of the symbol
		// range, EOS inside a string, and final bytes that decode nothing.
		syms = '{48, 49, 50, 97};              queue_string(syms, 0);
		syms = '{0, 255, 10, 13, 22};          queue_string(syms, 0);
		syms = '{EosCode, 101};                queue_string(syms, 0);
		syms = {};                             queue_string(syms, 0);
		syms = '{115, 116, 48};                queue_string(syms, 2);
		syms = '{1, 127, 128, 254};            queue_string(syms, 1);
		pending_bytes.push_back(in_item_t'{data_byte: 8'h00, final_byte: 1'b1});
		pending_bytes.push_back(in_item_t'{data_byte: 8'hFF, final_byte: 1'b1});
		pending_bytes.push_back(in_item_t'{data_byte: 8'hAA, final_byte: 1'b0});
		pending_bytes.push_back(in_item_t'{data_byte: 8'h55, final_byte: 1'b1});

		// Random part: mostly well-formed strings, some noise bytes.
		while (pending_bytes.size() < 700) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				queue_noise($urandom_range(1, 4), $urandom_range(0, 4) != 0);
			end else begin
				syms = {};
				repeat ($urandom_range(0, 12)) begin
					r = $urandom_range(0, 99);
					if (r < 3) syms.push_back(EosCode);
					else if (r < 70) syms.push_back(short_syms[$urandom_range(0, short_syms.size()-1)]);
					else syms.push_back($urandom_range(0, 255));
				end
				queue_string(syms, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d coded bytes in %0d well-formed strings plus noise, %0d with EOS.",
			n_bytes, n_strings, n_eos);
		$display("Checked %0d decoded results, %0d mismatches.", n_results, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
